@@ sv/fpsa_pkg.sv @@
package fpsa_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = IDX_W + 1;           // bank bit on top
    localparam int END_W       = 32 + IDX_W + 1;      // packed end, never wraps

    localparam logic [2:0] OP_ALLOC   = 3'd0;
    localparam logic [2:0] OP_RELEASE = 3'd1;
    localparam logic [2:0] OP_ADD     = 3'd2;
    localparam logic [2:0] OP_COMPACT = 3'd3;
    localparam logic [2:0] OP_RESET   = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_NOCONT = 2'd3;

    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic REG_FIT_METHOD  = 1'b0;
    localparam logic REG_MEMORY_SIZE = 1'b1;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] size;
        logic        hole;
        logic [15:0] owner;
    } t_entry;

    typedef enum logic [1:0] {
        KIND_FAIL = 2'd0,
        KIND_INIT = 2'd1,
        KIND_SCAN = 2'd2,
        KIND_COPY = 2'd3
    } t_kind;

    typedef struct packed {
        logic load;
        logic boot;
        logic init;
        logic scan;
        logic copy;
        logic tail;
        logic flush;
        logic result;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  src_end;
        logic  scan_fail;
        logic  abort_now;
        logic  copy_fail;
        logic  out_free;
    } t_dp_sts;

endpackage

@@ sv/fpsa_if.sv @@
interface fpsa_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [31:0] size;
    logic [31:0] base;
    logic [15:0] owner;

    modport source (output valid, output op, output size, output base, output owner,
                    input ready);
    modport sink   (input valid, input op, input size, input base, input owner,
                    output ready);
endinterface

interface fpsa_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] seg_start;
    logic [6:0]  seg_total;

    modport source (output valid, output status, output seg_start, output seg_total,
                    input ready);
    modport sink   (input valid, input status, input seg_start, input seg_total,
                    output ready);
endinterface

@@ sv/fpsa_ctrl.sv @@
module fpsa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fpsa_pkg::t_dp_sts i_sts,
    output fpsa_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_BOOT  = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_PREP  = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_COPY  = 8'b0001_0000,
        S_TAIL  = 8'b0010_0000,
        S_FLUSH = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_BOOT: begin
                o_cmd.boot = 1'b1;
                n_state    = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                case (i_sts.kind)
                    fpsa_pkg::KIND_INIT: begin
                        o_cmd.init = 1'b1;
                        n_state    = S_DONE;
                    end
                    fpsa_pkg::KIND_SCAN: n_state = S_SCAN;
                    fpsa_pkg::KIND_COPY: n_state = S_COPY;
                    default:             n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.src_end) begin
                    n_state = i_sts.scan_fail ? S_DONE : S_COPY;
                end
            end
            S_COPY: begin
                o_cmd.copy = 1'b1;
                if (i_sts.abort_now) begin
                    n_state = S_DONE;
                end else if (i_sts.src_end) begin
                    n_state = i_sts.copy_fail ? S_DONE : S_TAIL;
                end
            end
            S_TAIL: begin
                o_cmd.tail = 1'b1;
                n_state    = S_FLUSH;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.result = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_BOOT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/fpsa_dp.sv @@
module fpsa_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fpsa_pkg::t_dp_cmd i_cmd,
    output fpsa_pkg::t_dp_sts o_sts,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  logic [2:0]        i_op,
    input  logic [31:0]       i_size,
    input  logic [31:0]       i_base,
    input  logic [15:0]       i_owner,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic [31:0]       o_seg_start,
    output logic [6:0]        o_seg_total
);

    localparam int MAX = fpsa_pkg::MAX_ENTRIES;
    localparam int IW  = fpsa_pkg::IDX_W;
    localparam int CW  = fpsa_pkg::CNT_W;
    localparam int AW  = fpsa_pkg::ADDR_W;
    localparam int EW  = fpsa_pkg::END_W;

    // two banks: each pass reads bank r_bank and rewrites the other
    fpsa_pkg::t_entry mem [2*MAX];

    logic [1:0]       r_fit;
    logic [31:0]      r_msize;
    logic [2:0]       r_op;
    logic [31:0]      r_size, r_base;
    logic [15:0]      r_owner;
    logic             r_bank, n_bank;
    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_src_idx, n_src_idx;
    logic [1:0]       r_phase, n_phase;
    fpsa_pkg::t_entry r_rd;
    logic [CW-1:0]    r_dst_cnt, n_dst_cnt;
    fpsa_pkg::t_entry r_hold, n_hold;
    logic             r_hold_v, n_hold_v;
    logic             r_best_v, n_best_v;
    logic [IW-1:0]    r_best_idx, n_best_idx;
    logic [31:0]      r_best_size, n_best_size;
    logic [31:0]      r_best_base, n_best_base;
    logic             r_match, n_match;
    logic [EW-1:0]    r_end, n_end;
    logic [1:0]       r_status, n_status;
    logic             r_out_v;
    logic [1:0]       r_out_status;
    logic [31:0]      r_out_start;
    logic [6:0]       r_out_total;

    logic             src_end, pre_fail, take;
    logic             alloc_hit, exact;
    logic [32:0]      sb, se, ea, ba;
    logic             contains, add_hit, front, back, full_add;
    logic [1:0]       n_emit, sel;
    logic             last, abort_now;
    fpsa_pkg::t_entry c_emit, tail_e, w_e;
    logic             end_fits, tail_v, w_v, merge;
    logic [32:0]      msum;
    logic             we;
    logic [AW-1:0]    waddr;
    fpsa_pkg::t_entry wdata;
    logic [31:0]      start_val;

    assign src_end = r_src_idx >= r_count;

    assign pre_fail = (i_op > fpsa_pkg::OP_RESET) ||
                      ((i_op == fpsa_pkg::OP_ALLOC || i_op == fpsa_pkg::OP_ADD) &&
                       i_size == 32'd0);

    // hole choice, one entry a cycle
    always_comb begin
        take = 1'b0;
        if (r_rd.hole && r_rd.size >= r_size) begin
            case (r_fit)
                fpsa_pkg::FIT_BEST:  take = !r_best_v || r_rd.size < r_best_size;
                fpsa_pkg::FIT_WORST: take = !r_best_v || r_rd.size > r_best_size;
                default:             take = !r_best_v;
            endcase
        end
    end

    assign alloc_hit = r_best_v && (r_src_idx[IW-1:0] == r_best_idx);
    assign exact     = r_best_size == r_size;

    // add-hole containment on 33-bit addresses
    assign sb       = {1'b0, r_rd.base};
    assign se       = sb + {1'b0, r_rd.size};
    assign ba       = {1'b0, r_base};
    assign ea       = ba + {1'b0, r_size};
    assign contains = !r_rd.hole && ba >= sb && ba < se && ea <= se;
    assign add_hit  = contains && (!r_match || r_phase != 2'd0);
    assign front    = ba != sb;
    assign back     = ea < se;
    // new entries: the front piece and the back piece, the hole takes the old slot
    assign full_add = ({1'b0, r_count} + (CW+1)'(back) + (CW+1)'(front)) > (CW+1)'(MAX);

    // entries emitted for the current source entry
    always_comb begin
        n_emit = 2'd1;
        c_emit = r_rd;
        sel    = r_phase + {1'b0, !front};
        case (r_op)
            fpsa_pkg::OP_ALLOC: begin
                if (alloc_hit) begin
                    if (exact) begin
                        c_emit = '{r_rd.base, r_rd.size, 1'b0, r_owner};
                    end else begin
                        n_emit = 2'd2;
                        if (r_phase == 2'd0) begin
                            c_emit = '{r_rd.base, r_size, 1'b0, r_owner};
                        end else begin
                            c_emit = '{r_rd.base + r_size, r_rd.size - r_size, 1'b1,
                                       r_rd.owner};
                        end
                    end
                end
            end
            fpsa_pkg::OP_RELEASE: begin
                if (r_rd.owner == r_owner) begin
                    c_emit = '{r_rd.base, r_rd.size, 1'b1, 16'd0};
                end
            end
            fpsa_pkg::OP_ADD: begin
                if (add_hit) begin
                    n_emit = 2'd1 + 2'(front) + 2'(back);
                    case (sel)
                        2'd0:    c_emit = '{r_rd.base, r_base - r_rd.base, 1'b0, r_rd.owner};
                        2'd1:    c_emit = '{r_base, r_size, 1'b1, 16'd0};
                        default: c_emit = '{ea[31:0], se[31:0] - ea[31:0], 1'b0, r_owner};
                    endcase
                end
            end
            fpsa_pkg::OP_COMPACT: begin
                if (r_rd.hole) begin
                    n_emit = 2'd0;
                end else begin
                    c_emit = '{r_end[31:0], r_rd.size, 1'b0, r_rd.owner};
                end
            end
            default: ;
        endcase
    end

    assign last      = (n_emit == 2'd0) || (r_phase == n_emit - 2'd1);
    assign abort_now = i_cmd.copy && !src_end && r_op == fpsa_pkg::OP_ADD && add_hit &&
                       r_phase == 2'd0 && full_add;

    assign end_fits = r_end <= EW'(r_msize);
    assign tail_v   = r_op == fpsa_pkg::OP_COMPACT && end_fits && r_dst_cnt < CW'(MAX);
    assign tail_e   = '{r_end[31:0], r_msize - r_end[31:0] + 32'd1, 1'b1, 16'd0};

    // writer: one entry held back so adjacent holes fold together
    assign w_v   = i_cmd.copy ? (!src_end && n_emit != 2'd0 && !abort_now)
                              : (i_cmd.tail && tail_v);
    assign w_e   = i_cmd.copy ? c_emit : tail_e;
    assign merge = r_hold_v && r_hold.hole && w_e.hole;
    assign msum  = {1'b0, r_hold.size} + {1'b0, w_e.size};

    always_comb begin
        we    = 1'b0;
        waddr = {!r_bank, IW'(r_dst_cnt - CW'(1))};
        wdata = r_hold;
        if (i_cmd.boot || i_cmd.init) begin
            we    = 1'b1;
            waddr = {r_bank, IW'(0)};
            wdata = '{32'd1, i_cmd.boot ? 32'd1 : r_msize, 1'b0, 16'd1};
        end else if ((w_v && !merge && r_hold_v) || (i_cmd.flush && r_hold_v)) begin
            we = 1'b1;
        end
    end

    always_comb begin
        n_bank      = r_bank;
        n_count     = r_count;
        n_src_idx   = r_src_idx;
        n_phase     = r_phase;
        n_dst_cnt   = r_dst_cnt;
        n_hold      = r_hold;
        n_hold_v    = r_hold_v;
        n_best_v    = r_best_v;
        n_best_idx  = r_best_idx;
        n_best_size = r_best_size;
        n_best_base = r_best_base;
        n_match     = r_match;
        n_end       = r_end;
        n_status    = r_status;

        if (i_cmd.load) begin
            n_src_idx = '0;
            n_phase   = '0;
            n_dst_cnt = '0;
            n_hold_v  = 1'b0;
            n_best_v  = 1'b0;
            n_match   = 1'b0;
            n_end     = EW'(1);
            n_status  = pre_fail ? fpsa_pkg::ST_NOFIT : fpsa_pkg::ST_OK;
        end
        if (i_cmd.init) begin
            n_count = CW'(1);
        end
        if (i_cmd.scan) begin
            if (!src_end) begin
                n_src_idx = r_src_idx + CW'(1);
                if (take) begin
                    n_best_v    = 1'b1;
                    n_best_idx  = r_src_idx[IW-1:0];
                    n_best_size = r_rd.size;
                    n_best_base = r_rd.base;
                end
            end else begin
                n_src_idx = '0;
                if (!r_best_v) begin
                    n_status = fpsa_pkg::ST_NOFIT;
                end else if (!exact && r_count >= CW'(MAX)) begin
                    n_status = fpsa_pkg::ST_FULL;
                end
            end
        end
        if (i_cmd.copy) begin
            if (abort_now) begin
                n_status = fpsa_pkg::ST_FULL;
            end else if (!src_end) begin
                if (last) begin
                    n_src_idx = r_src_idx + CW'(1);
                    n_phase   = '0;
                end else begin
                    n_phase = r_phase + 2'd1;
                end
                if (r_op == fpsa_pkg::OP_ADD && add_hit) begin
                    n_match = 1'b1;
                end
                if (r_op == fpsa_pkg::OP_COMPACT && !r_rd.hole) begin
                    n_end = r_end + EW'(r_rd.size);
                end
            end else if (r_op == fpsa_pkg::OP_ADD && !r_match) begin
                n_status = fpsa_pkg::ST_NOCONT;
            end
        end
        if (i_cmd.tail && r_op == fpsa_pkg::OP_COMPACT && end_fits &&
            r_dst_cnt >= CW'(MAX)) begin
            n_status = fpsa_pkg::ST_FULL;
        end
        if (w_v) begin
            if (merge) begin
                n_hold.size = msum[32] ? 32'hFFFF_FFFF : msum[31:0];
            end else begin
                n_hold    = w_e;
                n_hold_v  = 1'b1;
                n_dst_cnt = r_dst_cnt + CW'(1);
            end
        end
        if (i_cmd.flush) begin
            n_hold_v = 1'b0;
            n_bank   = !r_bank;
            n_count  = r_dst_cnt;
        end
    end

    assign start_val = (r_op == fpsa_pkg::OP_COMPACT) ? r_end[31:0] :
                       (r_op == fpsa_pkg::OP_ALLOC && r_status == fpsa_pkg::ST_OK) ?
                       r_best_base : 32'd0;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd <= mem[{r_bank, n_src_idx[IW-1:0]}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit     <= '0;
            r_msize   <= 32'd1;
            r_bank    <= 1'b0;
            r_count   <= CW'(1);
            r_src_idx <= '0;
            r_phase   <= '0;
            r_dst_cnt <= '0;
            r_hold_v  <= 1'b0;
            r_best_v  <= 1'b0;
            r_match   <= 1'b0;
            r_status  <= fpsa_pkg::ST_OK;
            r_out_v   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    fpsa_pkg::REG_FIT_METHOD:  r_fit   <= i_cfg_data[1:0];
                    fpsa_pkg::REG_MEMORY_SIZE: r_msize <= i_cfg_data;
                    default: ;
                endcase
            end
            r_bank    <= n_bank;
            r_count   <= n_count;
            r_src_idx <= n_src_idx;
            r_phase   <= n_phase;
            r_dst_cnt <= n_dst_cnt;
            r_hold_v  <= n_hold_v;
            r_best_v  <= n_best_v;
            r_match   <= n_match;
            r_status  <= n_status;
            if (i_cmd.result) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_size  <= i_size;
            r_base  <= i_base;
            r_owner <= i_owner;
        end
        r_hold      <= n_hold;
        r_best_idx  <= n_best_idx;
        r_best_size <= n_best_size;
        r_best_base <= n_best_base;
        r_end       <= n_end;
        if (i_cmd.result) begin
            r_out_status <= r_status;
            r_out_start  <= start_val;
            r_out_total  <= 7'(r_count);
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.src_end   = src_end;
        o_sts.scan_fail = !r_best_v || (!exact && r_count >= CW'(MAX));
        o_sts.abort_now = abort_now;
        o_sts.copy_fail = r_op == fpsa_pkg::OP_ADD && !r_match;
        o_sts.out_free  = !r_out_v || i_ready;
        if (r_status != fpsa_pkg::ST_OK) begin
            o_sts.kind = fpsa_pkg::KIND_FAIL;
        end else if (r_op == fpsa_pkg::OP_RESET) begin
            o_sts.kind = fpsa_pkg::KIND_INIT;
        end else if (r_op == fpsa_pkg::OP_ALLOC) begin
            o_sts.kind = fpsa_pkg::KIND_SCAN;
        end else begin
            o_sts.kind = fpsa_pkg::KIND_COPY;
        end
    end

    assign o_valid     = r_out_v;
    assign o_status    = r_out_status;
    assign o_seg_start = r_out_start;
    assign o_seg_total = r_out_total;

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX))
        else $error("table count above capacity");
    a_dst_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dst_cnt <= CW'(MAX))
        else $error("rebuilt table above capacity");
    a_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> (r_bank != $past(r_bank)) && (r_count == $past(r_dst_cnt)))
        else $error("commit did not swap banks");
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != 2'd3)
        else $error("emission phase out of range");

endmodule

@@ sv/fit_policy_segment_allocator_unit.sv @@
// Segment allocator over an address-ordered table of up to 64 segments
// (base, size, hole flag, owner), with first, best or worst fit. One request
// beat in, one response beat out. Release, add, compact and an allocate
// whose fit scan succeeds rebuild the table by streaming it from one bank of
// a single-port-read memory into the other, entry by entry, folding adjacent
// holes on the way; a failed operation does not swap banks, so it leaves the
// table untouched, except that a compaction that finds no slot for its tail
// hole still commits. Allocate runs a fit scan before its pass; reset,
// zero-size and unknown ops make no pass. A response still waiting in the
// output register when the next one is ready holds the block until taken.
// A new request is taken while the previous response still waits in the
// output register. Configuration (fit_method, memory_size) is written through
// the cfg port; the user must write it only between requests, as the block
// itself does not enforce this.
module fit_policy_segment_allocator_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    fpsa_req_if.sink    i_req,
    fpsa_rsp_if.source  o_rsp
);

    fpsa_pkg::t_dp_cmd cmd;
    fpsa_pkg::t_dp_sts sts;
    logic              in_ready;

    // sequencer: boot, reset, fit scan, rebuild pass, tail, commit, respond
    fpsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // table banks, writer with hole folding, output register
    fpsa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_op        (i_req.op),
        .i_size      (i_req.size),
        .i_base      (i_req.base),
        .i_owner     (i_req.owner),
        .o_valid     (o_rsp.valid),
        .i_ready     (o_rsp.ready),
        .o_status    (o_rsp.status),
        .o_seg_start (o_rsp.seg_start),
        .o_seg_total (o_rsp.seg_total)
    );

    assign i_req.ready = in_ready;

endmodule

@@ dv/fpsa_seg_checker.sv @@
`timescale 1ns / 1ps

module fpsa_seg_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic [2:0]  i_req_op,
    input  logic [31:0] i_req_size,
    input  logic [31:0] i_req_base,
    input  logic [15:0] i_req_owner,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [1:0]  i_rsp_status,
    input  logic [31:0] i_rsp_seg_start,
    input  logic [6:0]  i_rsp_seg_total,
    output int          o_errors,
    output int          o_pending,
    output int          o_beats_out
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] seg_start;
        logic [6:0]  seg_total;
    } t_answer;

    fpsa_pkg::t_entry seg_tab [fpsa_pkg::MAX_ENTRIES];
    int      seg_cnt;
    logic [1:0]  fit_sel;
    logic [31:0] mem_units;
    t_answer answer_q [$];

    function automatic void shift_up(int pos);
        for (int k = seg_cnt; k > pos; k--) seg_tab[k] = seg_tab[k-1];
        seg_cnt++;
    endfunction

    function automatic void shift_down(int pos);
        for (int k = pos; k + 1 < seg_cnt; k++) seg_tab[k] = seg_tab[k+1];
        seg_cnt--;
    endfunction

    function automatic void fold_holes();
        int i;
        logic [32:0] sum;
        i = 0;
        while (i + 1 < seg_cnt) begin
            if (seg_tab[i].hole && seg_tab[i+1].hole) begin
                sum = {1'b0, seg_tab[i].size} + seg_tab[i+1].size;
                seg_tab[i].size = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                shift_down(i + 1);
            end else begin
                i++;
            end
        end
    endfunction

    function automatic void one_segment();
        for (int k = 0; k < fpsa_pkg::MAX_ENTRIES; k++) seg_tab[k] = '0;
        seg_tab[0] = '{base: 32'd1, size: mem_units, hole: 1'b0, owner: 16'd1};
        seg_cnt = 1;
    endfunction

    // Applies one request to the shadow table and returns the answer it earns.
    function automatic t_answer predict_segments(logic [2:0] op, logic [31:0] size,
                                                 logic [31:0] base, logic [15:0] owner);
        t_answer a;
        int h, need, pos;
        logic [32:0] sb, se, e, pend;
        logic [31:0] hb;
        a = '0;
        case (op)
            fpsa_pkg::OP_ALLOC: begin
                h = -1;
                if (size == 0) a.status = fpsa_pkg::ST_NOFIT;
                else begin
                    for (int i = 0; i < seg_cnt; i++) begin
                        if (!seg_tab[i].hole || seg_tab[i].size < size) continue;
                        if (fit_sel == fpsa_pkg::FIT_BEST) begin
                            if (h < 0 || seg_tab[i].size < seg_tab[h].size) h = i;
                        end else if (fit_sel == fpsa_pkg::FIT_WORST) begin
                            if (h < 0 || seg_tab[i].size > seg_tab[h].size) h = i;
                        end else if (h < 0) begin
                            h = i;
                        end
                    end
                    if (h < 0) a.status = fpsa_pkg::ST_NOFIT;
                    else begin
                        hb = seg_tab[h].base;
                        if (seg_tab[h].size == size) begin
                            seg_tab[h].hole = 1'b0;
                            seg_tab[h].owner = owner;
                            a.seg_start = hb;
                        end else if (seg_cnt >= fpsa_pkg::MAX_ENTRIES) begin
                            a.status = fpsa_pkg::ST_FULL;
                        end else begin
                            shift_up(h);
                            seg_tab[h] = '{base: hb, size: size, hole: 1'b0, owner: owner};
                            seg_tab[h+1].base = hb + size;
                            seg_tab[h+1].size = seg_tab[h+1].size - size;
                            a.seg_start = hb;
                        end
                    end
                end
            end
            fpsa_pkg::OP_RELEASE: begin
                for (int i = 0; i < seg_cnt; i++)
                    if (seg_tab[i].owner == owner) begin
                        seg_tab[i].hole = 1'b1;
                        seg_tab[i].owner = '0;
                    end
                fold_holes();
            end
            fpsa_pkg::OP_ADD: begin
                if (size == 0) a.status = fpsa_pkg::ST_NOFIT;
                else begin
                    a.status = fpsa_pkg::ST_NOCONT;
                    e = {1'b0, base} + size;
                    for (int i = 0; i < seg_cnt; i++) begin
                        if (seg_tab[i].hole) continue;
                        sb = {1'b0, seg_tab[i].base};
                        se = sb + seg_tab[i].size;
                        if (!(base >= sb && base < se && e <= se)) continue;
                        need = 1 + (e < se) - (base == sb);
                        if (seg_cnt + need > fpsa_pkg::MAX_ENTRIES) begin
                            a.status = fpsa_pkg::ST_FULL;
                            break;
                        end
                        if (base == sb) begin
                            seg_tab[i] = '{base: base, size: size, hole: 1'b1, owner: '0};
                            pos = i;
                        end else begin
                            seg_tab[i].size = 32'(base - sb);
                            shift_up(i + 1);
                            seg_tab[i+1] = '{base: base, size: size, hole: 1'b1, owner: '0};
                            pos = i + 1;
                        end
                        if (e < se) begin
                            shift_up(pos + 1);
                            seg_tab[pos+1] = '{base: e[31:0], size: 32'(se - e),
                                               hole: 1'b0, owner: owner};
                        end
                        fold_holes();
                        a.status = fpsa_pkg::ST_OK;
                        break;
                    end
                end
            end
            fpsa_pkg::OP_COMPACT: begin
                need = 0;
                pend = 33'd1;
                for (int i = 0; i < seg_cnt; i++) begin
                    if (seg_tab[i].hole) continue;
                    seg_tab[need] = '{base: pend[31:0], size: seg_tab[i].size,
                                      hole: 1'b0, owner: seg_tab[i].owner};
                    pend += seg_tab[i].size;
                    need++;
                end
                for (int i = need; i < seg_cnt; i++) seg_tab[i] = '0;
                seg_cnt = need;
                a.seg_start = pend[31:0];
                // the table always spans one contiguous range, so 33 bits hold its end
                if (pend <= {1'b0, mem_units}) begin
                    if (seg_cnt >= fpsa_pkg::MAX_ENTRIES) a.status = fpsa_pkg::ST_FULL;
                    else begin
                        seg_tab[seg_cnt] = '{base: pend[31:0],
                                            size: 32'({1'b0, mem_units} - pend + 1),
                                            hole: 1'b1, owner: '0};
                        seg_cnt++;
                    end
                end
            end
            fpsa_pkg::OP_RESET: one_segment();
            default: a.status = fpsa_pkg::ST_NOFIT;
        endcase
        a.seg_total = 7'(seg_cnt);
        return a;
    endfunction

    always_ff @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            fit_sel = '0;
            mem_units = 32'd1;
            one_segment();
            answer_q.delete();
            o_errors <= 0;
            o_beats_out <= 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == fpsa_pkg::REG_FIT_METHOD) fit_sel = i_cfg_data[1:0];
                else mem_units = i_cfg_data;
            end
            if (i_req_valid && i_req_ready)
                answer_q.insert(answer_q.size(), predict_segments(i_req_op, i_req_size,
                                                                  i_req_base, i_req_owner));
            if (i_rsp_valid && i_rsp_ready) begin
                o_beats_out <= o_beats_out + 1;
                if (answer_q.size() == 0) begin
                    $display("%0t: unexpected beat status=%0d start=%0h total=%0d",
                             $time, i_rsp_status, i_rsp_seg_start, i_rsp_seg_total);
                    o_errors <= o_errors + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (want !== {i_rsp_status, i_rsp_seg_start, i_rsp_seg_total}) begin
                        $display("%0t: expected status=%0d start=%0h total=%0d, got status=%0d start=%0h total=%0d",
                                 $time, want.status, want.seg_start, want.seg_total,
                                 i_rsp_status, i_rsp_seg_start, i_rsp_seg_total);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= answer_q.size();
    end

endmodule

@@ dv/tb_fit_policy_segment_allocator_unit.sv @@
`timescale 1ns / 1ps

module tb_fit_policy_segment_allocator_unit;

    localparam int TIMEOUT_CYCLES = 4_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [31:0] cfg_data;
    int          n_errors;
    int          n_pending;
    int          n_beats_out;
    int          n_beats_in;
    int          cycle_cnt = 0;

    fpsa_req_if req_ch ();
    fpsa_rsp_if rsp_ch ();

    fit_policy_segment_allocator_unit i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_req     (req_ch.sink),
        .o_rsp     (rsp_ch.source)
    );

    fpsa_seg_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_req_valid    (req_ch.valid),
        .i_req_ready    (req_ch.ready),
        .i_req_op       (req_ch.op),
        .i_req_size     (req_ch.size),
        .i_req_base     (req_ch.base),
        .i_req_owner    (req_ch.owner),
        .i_rsp_valid    (rsp_ch.valid),
        .i_rsp_ready    (rsp_ch.ready),
        .i_rsp_status   (rsp_ch.status),
        .i_rsp_seg_start(rsp_ch.seg_start),
        .i_rsp_seg_total(rsp_ch.seg_total),
        .o_errors       (n_errors),
        .o_pending      (n_pending),
        .o_beats_out    (n_beats_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > TIMEOUT_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Response side: random backpressure per beat, a random stall before each
    // ready, with stall-free stretches mixed in.
    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (stall != 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge i_clk iff rsp_ch.valid);
        end
    end

    task automatic write_reg(logic idx, logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait until every predicted answer is back, then a margin for the last
    // beat to settle inside the block.
    task automatic drain();
        int guard;
        guard = 0;
        @(posedge i_clk);
        @(posedge i_clk);
        while (n_pending != 0 && guard < 200_000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (300) @(posedge i_clk);
    endtask

    // One request beat. A random gap precedes it unless told
    // to go back-to-back.
    task automatic send_op(logic [2:0] op, logic [31:0] size, logic [31:0] base,
                           logic [15:0] owner, bit no_gap = 0);
        int gap;
        gap = (no_gap || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.size  <= size;
        req_ch.base  <= base;
        req_ch.owner <= owner;
        @(posedge i_clk iff req_ch.ready);
        n_beats_in++;
    endtask

    task automatic idle_req();
        req_ch.valid <= 1'b0;
    endtask

    // Size drawn across the whole field now and then, mostly small.
    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'd0;
            default: return $urandom_range(1, 40);
        endcase
    endfunction

    // Random phase: mostly well-formed traffic on a small owner set so that
    // releases and holes actually hit live segments; some raw noise too.
    task automatic random_phase(int count, logic [31:0] msize);
        int pick;
        logic [31:0] b;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_op(fpsa_pkg::OP_ALLOC, rand_size(), $urandom(),
                        16'($urandom_range(1, 6)));
            else if (pick < 62)
                send_op(fpsa_pkg::OP_RELEASE, $urandom(), $urandom(),
                        16'($urandom_range(0, 7)));
            else if (pick < 82) begin
                b = $urandom_range(1, (msize > 200 || msize == 0) ? 200 : msize);
                send_op(fpsa_pkg::OP_ADD, $urandom_range(0, 12), b,
                        16'($urandom_range(1, 6)));
            end else if (pick < 90)
                send_op(fpsa_pkg::OP_COMPACT, $urandom(), $urandom(), 16'($urandom()));
            else if (pick < 93)
                send_op(fpsa_pkg::OP_RESET, $urandom(), $urandom(), 16'($urandom()));
            else if (pick < 96)
                send_op(3'($urandom_range(5, 7)), $urandom(), $urandom(), 16'($urandom()));
            else
                send_op(fpsa_pkg::OP_ADD, $urandom(), $urandom(), 16'($urandom()));
        end
        idle_req();
    endtask

    initial begin
        logic [31:0] msizes [6];
        n_beats_in   = 0;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = fpsa_pkg::REG_FIT_METHOD;
        cfg_data     = '0;
        req_ch.valid = 1'b0;
        req_ch.op    = fpsa_pkg::OP_ALLOC;
        req_ch.size  = '0;
        req_ch.base  = '0;
        req_ch.owner = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset defaults, then edges of every field and op.
        send_op(fpsa_pkg::OP_ALLOC, 32'd1, '0, 16'hFFFF);
        send_op(fpsa_pkg::OP_COMPACT, '0, '0, '0);
        send_op(fpsa_pkg::OP_RELEASE, '0, '0, 16'd1);
        idle_req();
        drain();
        write_reg(fpsa_pkg::REG_MEMORY_SIZE, 32'd100);
        write_reg(fpsa_pkg::REG_FIT_METHOD, 32'(fpsa_pkg::FIT_BEST));
        send_op(fpsa_pkg::OP_RESET, '0, '0, '0);
        send_op(fpsa_pkg::OP_ALLOC, '0, '0, 16'd2);        // zero size refused
        send_op(fpsa_pkg::OP_ADD, '0, 32'd5, 16'd2);       // zero hole refused
        send_op(fpsa_pkg::OP_ADD, 32'd10, 32'd1, 16'd3);   // hole at segment base
        send_op(fpsa_pkg::OP_ADD, 32'd20, 32'd40, 16'd4);  // hole mid segment
        send_op(fpsa_pkg::OP_ADD, 32'd5, 32'd95, 16'd5);   // hole one unit short of segment tail
        send_op(fpsa_pkg::OP_ADD, 32'd5, 32'd2, 16'd5);    // inside a hole: refused
        send_op(fpsa_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(fpsa_pkg::OP_ALLOC, 32'd10, '0, 16'd6);    // exact fit
        send_op(fpsa_pkg::OP_ALLOC, 32'd3, '0, 16'd7);     // best fit split
        send_op(fpsa_pkg::OP_ALLOC, 32'd500, '0, 16'd7);   // nothing fits
        send_op(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_op(3'd5, '0, '0, '0);
        send_op(fpsa_pkg::OP_RELEASE, '0, '0, 16'd0);      // owner 0 = holes
        send_op(fpsa_pkg::OP_RELEASE, '0, '0, 16'd4);
        send_op(fpsa_pkg::OP_COMPACT, '0, '0, '0);
        send_op(fpsa_pkg::OP_RELEASE, '0, '0, 16'd1);
        send_op(fpsa_pkg::OP_RELEASE, '0, '0, 16'd7);
        send_op(fpsa_pkg::OP_COMPACT, '0, '0, '0);         // owners 3, 5 and 6 still hold segments
        idle_req();
        drain();
        // Fill the table to the limit with 1-unit holes, then overfill.
        write_reg(fpsa_pkg::REG_MEMORY_SIZE, 32'd200);
        write_reg(fpsa_pkg::REG_FIT_METHOD, 32'(fpsa_pkg::FIT_WORST));
        send_op(fpsa_pkg::OP_RESET, '0, '0, '0);
        for (int k = 0; k < 70; k++)
            send_op(fpsa_pkg::OP_ADD, 32'd1, 32'(2 * k + 2), 16'($urandom_range(1, 3)), 1);
        send_op(fpsa_pkg::OP_ALLOC, 32'd1, '0, 16'd9);
        send_op(fpsa_pkg::OP_COMPACT, '0, '0, '0);
        idle_req();
        drain();
        // Hole merge up to the full 32-bit size and wrapping addresses at full memory size.
        write_reg(fpsa_pkg::REG_MEMORY_SIZE, 32'hFFFF_FFFF);
        write_reg(fpsa_pkg::REG_FIT_METHOD, 32'd3);
        send_op(fpsa_pkg::OP_RESET, '0, '0, '0);
        send_op(fpsa_pkg::OP_ADD, 32'hFFFF_FFF0, 32'd1, 16'd2);
        send_op(fpsa_pkg::OP_RELEASE, '0, '0, 16'd2);
        send_op(fpsa_pkg::OP_ALLOC, 32'hFFFF_FFFF, '0, 16'd2);
        send_op(fpsa_pkg::OP_COMPACT, '0, '0, '0);
        idle_req();
        drain();

        // Random phases across register settings, extremes included.
        msizes = '{32'd1, 32'd64, 32'd150, 32'd1000, 32'hFFFF_FFFF, 32'd37};
        for (int p = 0; p < 6; p++) begin
            write_reg(fpsa_pkg::REG_MEMORY_SIZE, msizes[p]);
            write_reg(fpsa_pkg::REG_FIT_METHOD, 32'(p % 4));
            send_op(fpsa_pkg::OP_RESET, '0, '0, '0, 1);
            send_op(fpsa_pkg::OP_RELEASE, '0, '0, 16'd1, 1); // free memory to work in
            random_phase(157, msizes[p]);
            drain();                                       // sender holds off here
        end

        $display("Covered %0d request beats, %0d response beats: all five ops plus bad ops,",
                 n_beats_in, n_beats_out);
        $display("first/best/worst fit, table overflow, merges and compaction at several sizes.");
        if (n_errors == 0 && n_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/fpsa_pkg.sv
sv/fpsa_if.sv
sv/fpsa_ctrl.sv
sv/fpsa_dp.sv
sv/fit_policy_segment_allocator_unit.sv
dv/fpsa_seg_checker.sv
dv/tb_fit_policy_segment_allocator_unit.sv
